@@ rtl/core/ence_pkg.sv @@
// ----------------------------------------------------------------------------
// ence_pkg
// shared widths, register codes and control/status types for the elliptic
// neighbour cell enumerator
// ----------------------------------------------------------------------------
package ence_pkg;

  localparam int GRID_W  = 7;
  localparam int RAD_W   = 2;
  localparam int COORD_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W   = 3;

  localparam int MAX_GRID_DEF   = 64;
  localparam int MAX_RADIUS_DEF = 3;

  localparam logic [GRID_W-1:0] GRID_RST = GRID_W'(8);
  localparam logic [RAD_W-1:0]  RAD_RST  = RAD_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE = 2'd0,
    REG_RADIUS_X  = 2'd1,
    REG_RADIUS_Y  = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic prep_step;
    logic walk_step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic bad_in;
    logic prep_last;
    logic walk_last;
  } stat_t;

  function automatic logic [3:0] sq2(input logic [RAD_W-1:0] x);
    sq2 = 4'(x * x);
  endfunction

endpackage

@@ rtl/core/ence_ctrl.sv @@
// ----------------------------------------------------------------------------
// ence_ctrl
// sequencer: load, radius preparation, offset walk and final transfer
// ----------------------------------------------------------------------------
module ence_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ence_pkg::stat_t stat,
  output ence_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_WALK = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = stat.bad_in ? ST_DONE : ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep_step = 1'b1;
        if (stat.prep_last) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_flush_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> state_r == ST_IDLE)
    else $error("flush not followed by idle");

  a_bad_skips_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && stat.bad_in) |=> state_r == ST_DONE)
    else $error("bad centre did not go straight to final transfer");

endmodule

@@ rtl/core/ence_datapath.sv @@
// ----------------------------------------------------------------------------
// ence_datapath
// config registers, wrapped coordinate counters, ellipse test, one-deep
// hold stage for the last flag and the result register
// ----------------------------------------------------------------------------
module ence_datapath #(
  parameter int MAX_GRID   = ence_pkg::MAX_GRID_DEF,
  parameter int MAX_RADIUS = ence_pkg::MAX_RADIUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ence_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ence_pkg::GRID_W-1:0]         cfg_data,
  input  logic [ence_pkg::COORD_W-1:0]        in_center_col,
  input  logic [ence_pkg::COORD_W-1:0]        in_center_row,
  input  ence_pkg::cmd_t                      cmd,
  output ence_pkg::stat_t                     stat,
  output logic                                out_valid,
  output logic [ence_pkg::COORD_W-1:0]        out_neighbour_col,
  output logic [ence_pkg::COORD_W-1:0]        out_neighbour_row,
  output logic                                out_found,
  output logic                                out_bad_center,
  output logic                                out_last
);

  localparam int GW   = ence_pkg::GRID_W;
  localparam int RW   = ence_pkg::RAD_W;
  localparam int CW   = ence_pkg::CNT_W;
  localparam int PCW  = $clog2(MAX_RADIUS + 1);

  logic [GW-1:0]  grid_r;
  logic [RW-1:0]  rx_r, ry_r;

  logic [GW-1:0]  g_eff, g_m1;
  logic [RW-1:0]  rx, ry;
  logic [CW-1:0]  rx3, ry3, ci_end, cj_end;

  logic [PCW-1:0] pc_r, pc_nxt;
  logic [CW-1:0]  ci_r, ci_nxt, cj_r, cj_nxt;
  logic [GW-1:0]  col_r, col_nxt, row_r, row_nxt, rs_r, rs_nxt;
  logic           bad_r, bad_nxt;
  logic           hold_v_r, hold_v_nxt;
  logic [GW-1:0]  hold_col_r, hold_col_nxt, hold_row_r, hold_row_nxt;

  logic                 ov_r, ov_nxt;
  logic [GW-1:0]        ocol_r, ocol_nxt, orow_r, orow_nxt;
  logic                 ofound_r, ofound_nxt, obad_r, obad_nxt, olast_r, olast_nxt;

  logic [CW-1:0]  ai3, aj3;
  logic [RW-1:0]  ai, aj;
  logic [8:0]     lhs;
  logic [7:0]     bound;
  logic           excluded, keep;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= ence_pkg::GRID_RST;
      rx_r   <= ence_pkg::RAD_RST;
      ry_r   <= ence_pkg::RAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ence_pkg::REG_GRID_SIZE: grid_r <= cfg_data;
        ence_pkg::REG_RADIUS_X:  rx_r   <= cfg_data[RW-1:0];
        ence_pkg::REG_RADIUS_Y:  ry_r   <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // saturated settings
  assign g_eff = ({2'b00, grid_r} > 9'(MAX_GRID)) ? GW'(MAX_GRID) : grid_r;
  assign g_m1  = g_eff - GW'(1);
  assign rx    = (rx_r > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : rx_r;
  assign ry    = (ry_r > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : ry_r;
  assign rx3   = {1'b0, rx};
  assign ry3   = {1'b0, ry};
  assign ci_end = {rx, 1'b0};
  assign cj_end = {ry, 1'b0};

  // ellipse test on the current offset
  assign ai3 = (ci_r < rx3) ? (rx3 - ci_r) : (ci_r - rx3);
  assign aj3 = (cj_r < ry3) ? (ry3 - cj_r) : (cj_r - ry3);
  assign ai  = ai3[RW-1:0];
  assign aj  = aj3[RW-1:0];
  assign lhs = 9'(ence_pkg::sq2(ai) * ence_pkg::sq2(ry))
             + 9'(ence_pkg::sq2(aj) * ence_pkg::sq2(rx));
  assign bound = 8'(ence_pkg::sq2(rx) * ence_pkg::sq2(ry));
  assign excluded = ((aj == '0) && ((ai == rx) || (ai == '0)))
                 || ((ai == '0) && (aj == ry));
  assign keep = !excluded && (lhs <= {1'b0, bound});

  assign stat.bad_in    = ({1'b0, in_center_col} >= g_eff)
                       || ({1'b0, in_center_row} >= g_eff);
  assign stat.prep_last = (pc_r == PCW'(MAX_RADIUS - 1));
  assign stat.walk_last = (ci_r == ci_end) && (cj_r == cj_end);

  always_comb begin
    pc_nxt       = pc_r;
    ci_nxt       = ci_r;
    cj_nxt       = cj_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    rs_nxt       = rs_r;
    bad_nxt      = bad_r;
    hold_v_nxt   = hold_v_r;
    hold_col_nxt = hold_col_r;
    hold_row_nxt = hold_row_r;
    ov_nxt       = 1'b0;
    ocol_nxt     = ocol_r;
    orow_nxt     = orow_r;
    ofound_nxt   = ofound_r;
    obad_nxt     = obad_r;
    olast_nxt    = olast_r;

    if (cmd.load) begin
      pc_nxt     = '0;
      ci_nxt     = '0;
      cj_nxt     = '0;
      col_nxt    = {1'b0, in_center_col};
      row_nxt    = {1'b0, in_center_row};
      rs_nxt     = {1'b0, in_center_row};
      bad_nxt    = stat.bad_in;
      hold_v_nxt = 1'b0;
    end

    // step back to the corner offset, one cell per cycle
    if (cmd.prep_step) begin
      pc_nxt = pc_r + PCW'(1);
      if (RW'(pc_r) < rx) col_nxt = (col_r == '0) ? g_m1 : col_r - GW'(1);
      if (RW'(pc_r) < ry) begin
        row_nxt = (row_r == '0) ? g_m1 : row_r - GW'(1);
        rs_nxt  = row_nxt;
      end
    end

    if (cmd.walk_step) begin
      if (cj_r == cj_end) begin
        cj_nxt  = '0;
        row_nxt = rs_r;
        ci_nxt  = (ci_r == ci_end) ? '0 : ci_r + CW'(1);
        col_nxt = (col_r == g_m1) ? '0 : col_r + GW'(1);
      end else begin
        cj_nxt  = cj_r + CW'(1);
        row_nxt = (row_r == g_m1) ? '0 : row_r + GW'(1);
      end
      if (keep) begin
        // previous neighbour is now known not to be the last
        if (hold_v_r) begin
          ov_nxt     = 1'b1;
          ocol_nxt   = hold_col_r;
          orow_nxt   = hold_row_r;
          ofound_nxt = 1'b1;
          obad_nxt   = 1'b0;
          olast_nxt  = 1'b0;
        end
        hold_v_nxt   = 1'b1;
        hold_col_nxt = col_r;
        hold_row_nxt = row_r;
      end
    end

    if (cmd.flush) begin
      ov_nxt     = 1'b1;
      ocol_nxt   = hold_v_r ? hold_col_r : '0;
      orow_nxt   = hold_v_r ? hold_row_r : '0;
      ofound_nxt = hold_v_r;
      obad_nxt   = bad_r;
      olast_nxt  = 1'b1;
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      ci_r     <= '0;
      cj_r     <= '0;
      bad_r    <= 1'b0;
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      ci_r     <= ci_nxt;
      cj_r     <= cj_nxt;
      bad_r    <= bad_nxt;
      hold_v_r <= hold_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    rs_r       <= rs_nxt;
    hold_col_r <= hold_col_nxt;
    hold_row_r <= hold_row_nxt;
    ocol_r     <= ocol_nxt;
    orow_r     <= orow_nxt;
    ofound_r   <= ofound_nxt;
    obad_r     <= obad_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid         = ov_r;
  assign out_neighbour_col = ocol_r[ence_pkg::COORD_W-1:0];
  assign out_neighbour_row = orow_r[ence_pkg::COORD_W-1:0];
  assign out_found         = ofound_r;
  assign out_bad_center    = obad_r;
  assign out_last          = olast_r;

  a_last_empties_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && olast_r) |-> !hold_v_r)
    else $error("neighbour still held after final transfer");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !ofound_r) |-> (olast_r && ocol_r == '0 && orow_r == '0))
    else $error("empty result not final or not zeroed");

  a_bad_has_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && obad_r) |-> ($past(cmd.load, 2) && !ofound_r))
    else $error("bad centre transfer not directly after load");

endmodule

@@ rtl/core/elliptic_neighbour_cell_enumerator.sv @@
// ----------------------------------------------------------------------------
// elliptic_neighbour_cell_enumerator
// lists the wrapped neighbour cells of a centre cell that lie inside an
// ellipse of radii radius_x, radius_y on a square toroidal grid
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. busy then stays high
// while the coordinate counters step back to the corner offset, while one
// offset of the rectangle is tested per cycle, and while a final transfer
// sends the last neighbour. A centre outside the grid skips the first two
// steps and goes straight to the final transfer. Results appear on out_* for
// one cycle each, marked by out_valid, and must be taken when shown;
// out_last flags the final one. If no offset qualifies, or the centre is
// outside the grid, a single transfer with out_found low is given.
// cfg_ready is always high; write the registers only while busy is low.
module elliptic_neighbour_cell_enumerator #(
  parameter int MAX_GRID   = ence_pkg::MAX_GRID_DEF,
  parameter int MAX_RADIUS = ence_pkg::MAX_RADIUS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ence_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ence_pkg::GRID_W-1:0]    cfg_data,
  input  logic                           start,
  output logic                           busy,
  input  logic [ence_pkg::COORD_W-1:0]   in_center_col,
  input  logic [ence_pkg::COORD_W-1:0]   in_center_row,
  output logic                           out_valid,
  output logic [ence_pkg::COORD_W-1:0]   out_neighbour_col,
  output logic [ence_pkg::COORD_W-1:0]   out_neighbour_row,
  output logic                           out_found,
  output logic                           out_bad_center,
  output logic                           out_last
);

  ence_pkg::cmd_t  cmd;
  ence_pkg::stat_t stat;
  logic            ctrl_busy;

  assign cfg_ready = 1'b1;
  assign busy      = ctrl_busy;

  ence_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (ctrl_busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ence_datapath #(
    .MAX_GRID   (MAX_GRID),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_center_col     (in_center_col),
    .in_center_row     (in_center_row),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_neighbour_col (out_neighbour_col),
    .out_neighbour_row (out_neighbour_row),
    .out_found         (out_found),
    .out_bad_center    (out_bad_center),
    .out_last          (out_last)
  );

endmodule
